// ----- rtl/dsl_pkg.sv -----
// ----------------------------------------------------------------------------
// dsl_pkg: shared types and constants for the dual servo limit controller
// Item kinds, result codes, fixed-point constants and encoder step helper.
// ----------------------------------------------------------------------------
package dsl_pkg;

  localparam int ENC_COUNTS    = 4096;
  localparam int ENC_QUARTER   = ENC_COUNTS / 4;
  localparam int POS_BITS_DEF  = 32;
  localparam int FACTOR_ONE    = 65536;
  localparam int FACTOR_STEP   = 6554;
  localparam int FACTOR_FRAC   = 16;
  localparam int DRIFT_DIVISOR = 5;
  // Drift / 5 by chunks: ceil(2^16 / 5) is exact for every 14-bit chunk value
  localparam int DRIFT_RECIP   = 13108;
  localparam int DRIFT_SHIFT   = 16;
  localparam int DRIFT_CHUNK   = 11;
  localparam int BAND_W        = 20;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_SET_VEL = 3'd1,
    KIND_ZERO    = 3'd2,
    KIND_SAFETY  = 3'd3,
    KIND_DISABLE = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ACT_SPEED  = 2'd0,
    ACT_TORQUE = 2'd1,
    ACT_PASSED = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_NO_RESP = 2'd1,
    FLT_LOAD    = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    CFG_MIN_LIMIT = 3'd0,
    CFG_MAX_LIMIT = 3'd1,
    CFG_BAND      = 3'd2,
    CFG_LOAD_LIM  = 3'd3,
    CFG_ACCEL     = 3'd4,
    CFG_REVERSE   = 3'd5
  } cfg_idx_t;

  // Signed encoder step; a step beyond +/- a quarter turn is unwrapped by one full turn.
  function automatic logic signed [13:0] enc_step(input logic [11:0] raw,
                                                  input logic [11:0] prev);
    logic signed [13:0] d;
    d = $signed({2'b00, raw}) - $signed({2'b00, prev});
    if (d > 14'(ENC_QUARTER)) begin
      d = d - 14'(ENC_COUNTS);
    end else if (d < -14'(ENC_QUARTER)) begin
      d = d + 14'(ENC_COUNTS);
    end
    return d;
  endfunction

endpackage

// ----- rtl/dual_servo_limit_sync_control.sv -----
// ----------------------------------------------------------------------------
// dual_servo_limit_sync_control
// Paired wheel servo controller: encoder unwrap, soft-limit slowdown, drift
// sync, safety check and torque off, on a shared restoring divider and a
// short chunked reciprocal multiply for the drift correction.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | kind, raw_pos_a/b, raw_ok_a/b, load_a/b, velocity_target
//  out     | out_valid/out_stall| action, speed_a/b, accel_out, halted, fault, fault_servo,
//          |                    | position_a/b, last
//  cfg     | cfg_we             | cfg_index, cfg_data
//
//  A tick with an active command runs S_DIST, then S_DIV inside the slowdown band (16
//  divider steps form the factor), S_MUL and S_DEC; an uncorrected pair beat in S_PAIR
//  may come next and ends the item when halted; otherwise S_DRIFT, S_DV5, S_SUM and S_FIN
//  register the last beat. Drift / 5 takes 3 multiply steps at the default width. Set
//  velocity runs S_DIST to S_PAIR, safety check and disable use S_SIMPLE, and zero,
//  unknown kinds and idle ticks give no beat; a stalled beat holds the output state.
//  in_stall is high while an item is in flight; a last result may still wait
//  in the output register while the next beat is taken. Reset (synchronous,
//  active low) clears positions, command and out_valid; previous factor resets to one.
module dual_servo_limit_sync_control
  import dsl_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [11:0]        in_raw_pos_a,
  input  logic               in_raw_ok_a,
  input  logic [11:0]        in_raw_pos_b,
  input  logic               in_raw_ok_b,
  input  logic signed [10:0] in_load_a,
  input  logic signed [10:0] in_load_b,
  input  logic signed [15:0] in_velocity_target,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_action,
  output logic signed [15:0] out_speed_a,
  output logic signed [15:0] out_speed_b,
  output logic [7:0]         out_accel_out,
  output logic               out_halted,
  output logic [1:0]         out_fault,
  output logic               out_fault_servo,
  output logic signed [31:0] out_position_a,
  output logic signed [31:0] out_position_b,
  output logic               out_last
);

  localparam int PB  = POSITION_BITS;
  localparam int EW  = ((PB > 32) ? PB : 32) + 2;  // distance / position math
  localparam int DVW = PB + 1;                     // drift magnitude / quotient
  localparam int CW  = $clog2(FACTOR_FRAC + 1);
  localparam int SW  = DVW + 3;                    // corrected speed sums
  localparam int RW  = BAND_W + 1;                 // partial remainder
  localparam int NCH = (DVW + DRIFT_CHUNK - 1) / DRIFT_CHUNK;
  localparam int XW  = NCH * DRIFT_CHUNK;
  localparam int VW  = DRIFT_CHUNK + 3;            // remainder and chunk

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_DIV, S_MUL, S_DEC, S_PAIR, S_DRIFT, S_DV5, S_SUM, S_FIN,
    S_SIMPLE
  } state_t;

  // Configuration registers
  logic signed [31:0]  min_limit_r, max_limit_r;
  logic [BAND_W-1:0]   band_r;
  logic [9:0]          load_lim_r;
  logic [7:0]          accel_r;
  logic                rev_r;

  // Block state
  logic [PB-1:0]       turns_a_r, turns_b_r;
  logic [11:0]         prev_a_r, prev_b_r;
  logic signed [15:0]  vel_r;
  logic [16:0]         prev_f_r;

  // Sequencer and per-item working registers
  state_t              state_r;
  logic signed [15:0]  vel_use_r;
  logic                is_set_r, halt_r, pair_last_r, neg_r;
  logic [16:0]         f_r;
  logic signed [16:0]  base_r;
  logic signed [SW-1:0] sa_r, sb_r;
  logic [1:0]          act_r, fault_r;
  logic                fsv_r;

  // Restoring divider for the slowdown factor
  logic [RW-1:0]       rem_r;
  logic [BAND_W-1:0]   div_r;
  logic [15:0]         quo_r;
  logic [CW-1:0]       cnt_r;

  // Chunked drift / 5
  logic [XW-1:0]       x5_r;
  logic [2:0]          r5_r;
  logic [DVW-1:0]      q5_r;

  // Output register
  logic                out_valid_r;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic signed [13:0]   stp_a, stp_b;
  logic [PB-1:0]        turns_a_nxt, turns_b_nxt, pb_raw;
  logic signed [EW-1:0] pa_ext, pb_ext, lim_dist, band_ext, drift;
  logic [BAND_W-1:0]    band_eff;
  logic [RW-1:0]        div_t;
  logic                 div_ge;
  logic signed [33:0]   prod, prod_c;
  logic [16:0]          f_diff;
  logic signed [SW-1:0] sync_v, base_sw;
  logic [10:0]          mag_a, mag_b;
  logic                 out_free, out_load;
  logic [VW-1:0]        v5, r5_full;
  logic [2*VW-1:0]      p5;
  logic [DRIFT_CHUNK-1:0] q5_dig;
  logic [2:0]           r5_nxt;

  function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
    if (v > SW'(32767)) begin
      return 16'sh7fff;
    end else if (v < -SW'(32768)) begin
      return -16'sh8000;
    end
    return 16'(v);
  endfunction

  always_comb begin
    stp_a       = enc_step(in_raw_pos_a, prev_a_r);
    stp_b       = enc_step(in_raw_pos_b, prev_b_r);
    turns_a_nxt = turns_a_r + PB'(stp_a);
    turns_b_nxt = turns_b_r + PB'(stp_b);
    pb_raw      = rev_r ? (PB'(0) - turns_b_r) : turns_b_r;
    pa_ext      = EW'(signed'(turns_a_r));
    pb_ext      = EW'(signed'(pb_raw));
    lim_dist    = (vel_use_r > 16'sd0) ? (EW'(max_limit_r) - pa_ext)
                                       : (pa_ext - EW'(min_limit_r));
    band_eff    = (band_r == '0) ? BAND_W'(1) : band_r;
    band_ext    = EW'({1'b0, band_eff});
    drift       = pa_ext - pb_ext;
    div_t       = {rem_r[RW-2:0], 1'b0};
    div_ge      = div_t >= {1'b0, div_r};
    prod        = 34'(vel_use_r) * 34'(signed'({1'b0, f_r}));
    prod_c      = (prod < 0) ? (prod + 34'sd65535) : prod;
    f_diff      = (f_r >= prev_f_r) ? (f_r - prev_f_r) : (prev_f_r - f_r);
    v5          = {r5_r, x5_r[XW-1 -: DRIFT_CHUNK]};
    p5          = (2*VW)'(v5) * (2*VW)'(DRIFT_RECIP);
    q5_dig      = p5[DRIFT_SHIFT +: DRIFT_CHUNK];
    r5_full     = v5 - VW'(q5_dig) * VW'(DRIFT_DIVISOR);
    r5_nxt      = r5_full[2:0];
    sync_v      = neg_r ? -SW'(signed'({1'b0, q5_r})) : SW'(signed'({1'b0, q5_r}));
    base_sw     = SW'(base_r);
    mag_a       = in_load_a[10] ? 11'(-in_load_a) : 11'(in_load_a);
    mag_b       = in_load_b[10] ? 11'(-in_load_b) : 11'(in_load_b);
    out_free    = !out_valid_r || !out_stall;
    out_load    = out_free && (state_r inside {S_PAIR, S_FIN, S_SIMPLE});
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_limit_r <= -32'sd999999;
      max_limit_r <= 32'sd999999;
      band_r      <= BAND_W'(2048);
      load_lim_r  <= 10'd800;
      accel_r     <= 8'd200;
      rev_r       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_LIMIT: min_limit_r <= cfg_data;
        CFG_MAX_LIMIT: max_limit_r <= cfg_data;
        CFG_BAND:      band_r      <= cfg_data[BAND_W-1:0];
        CFG_LOAD_LIM:  load_lim_r  <= cfg_data[9:0];
        CFG_ACCEL:     accel_r     <= cfg_data[7:0];
        CFG_REVERSE:   rev_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer, state and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      turns_a_r   <= '0;
      turns_b_r   <= '0;
      prev_a_r    <= '0;
      prev_b_r    <= '0;
      vel_r       <= '0;
      prev_f_r    <= 17'(FACTOR_ONE);
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once the far side takes it, unless a new one lands
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_kind)
              KIND_TICK: begin
                if (in_raw_ok_a) begin
                  turns_a_r <= turns_a_nxt;
                  prev_a_r  <= in_raw_pos_a;
                end
                if (in_raw_ok_b) begin
                  turns_b_r <= turns_b_nxt;
                  prev_b_r  <= in_raw_pos_b;
                end
                vel_use_r <= vel_r;
                is_set_r  <= 1'b0;
                if (vel_r != '0) begin
                  state_r <= S_DIST;
                end
              end
              KIND_SET_VEL: begin
                vel_r     <= in_velocity_target;
                vel_use_r <= in_velocity_target;
                is_set_r  <= 1'b1;
                state_r   <= S_DIST;
              end
              KIND_ZERO: begin
                if (in_raw_ok_a) prev_a_r <= in_raw_pos_a;
                if (in_raw_ok_b) prev_b_r <= in_raw_pos_b;
                turns_a_r <= '0;
                turns_b_r <= '0;
              end
              KIND_SAFETY: begin
                // Check servo a first, then servo b
                state_r <= S_SIMPLE;
                if (!in_raw_ok_a || mag_a > {1'b0, load_lim_r}) begin
                  act_r   <= ACT_TORQUE;
                  fault_r <= in_raw_ok_a ? FLT_LOAD : FLT_NO_RESP;
                  fsv_r   <= 1'b0;
                  vel_r   <= '0;
                end else if (!in_raw_ok_b || mag_b > {1'b0, load_lim_r}) begin
                  act_r   <= ACT_TORQUE;
                  fault_r <= in_raw_ok_b ? FLT_LOAD : FLT_NO_RESP;
                  fsv_r   <= 1'b1;
                  vel_r   <= '0;
                end else begin
                  act_r   <= ACT_PASSED;
                  fault_r <= FLT_NONE;
                  fsv_r   <= 1'b0;
                end
              end
              KIND_DISABLE: begin
                vel_r   <= '0;
                act_r   <= ACT_TORQUE;
                fault_r <= FLT_NONE;
                fsv_r   <= 1'b0;
                state_r <= S_SIMPLE;
              end
              default: ;
            endcase
          end
        end

        S_DIST: begin
          if (vel_use_r == '0 || lim_dist >= band_ext) begin
            f_r     <= 17'(FACTOR_ONE);
            halt_r  <= 1'b0;
            state_r <= S_MUL;
          end else if (lim_dist <= EW'(0)) begin
            f_r     <= '0;
            halt_r  <= 1'b1;
            state_r <= S_MUL;
          end else begin
            // Remaining distance is below the band: factor = dist * 2^16 / band
            halt_r  <= 1'b0;
            rem_r   <= RW'(lim_dist[BAND_W-1:0]);
            div_r   <= band_eff;
            quo_r   <= '0;
            cnt_r   <= CW'(FACTOR_FRAC);
            state_r <= S_DIV;
          end
        end

        S_DIV: begin
          rem_r <= div_ge ? (div_t - {1'b0, div_r}) : div_t;
          quo_r <= {quo_r[14:0], div_ge};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            f_r     <= {1'b0, quo_r[14:0], div_ge};
            state_r <= S_MUL;
          end
        end

        S_MUL: begin
          base_r  <= 17'(prod_c >>> FACTOR_FRAC);
          state_r <= S_DEC;
        end

        S_DEC: begin
          if (is_set_r) begin
            pair_last_r <= 1'b1;
            state_r     <= S_PAIR;
          end else if (halt_r || f_diff >= 17'(FACTOR_STEP)) begin
            prev_f_r    <= f_r;
            pair_last_r <= halt_r;
            if (halt_r) vel_r <= '0;
            state_r     <= S_PAIR;
          end else begin
            state_r <= S_DRIFT;
          end
        end

        S_PAIR: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_action      <= ACT_SPEED;
            out_speed_a     <= sat16(base_sw);
            out_speed_b     <= sat16(rev_r ? -base_sw : base_sw);
            out_accel_out   <= accel_r;
            out_halted      <= halt_r && !is_set_r;
            out_fault       <= FLT_NONE;
            out_fault_servo <= 1'b0;
            out_position_a  <= pa_ext[31:0];
            out_position_b  <= pb_ext[31:0];
            out_last        <= pair_last_r;
            state_r         <= pair_last_r ? S_IDLE : S_DRIFT;
          end
        end

        S_DRIFT: begin
          // Magnitude of drift divided by chunks, sign applied afterwards
          neg_r   <= drift < 0;
          x5_r    <= (drift < 0) ? XW'(-drift) : XW'(drift);
          r5_r    <= '0;
          q5_r    <= '0;
          cnt_r   <= CW'(NCH);
          state_r <= S_DV5;
        end

        S_DV5: begin
          x5_r  <= x5_r << DRIFT_CHUNK;
          r5_r  <= r5_nxt;
          q5_r  <= {q5_r[DVW-DRIFT_CHUNK-1:0], q5_dig};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_r <= S_SUM;
          end
        end

        S_SUM: begin
          sa_r    <= base_sw - sync_v;
          sb_r    <= base_sw + sync_v;
          state_r <= S_FIN;
        end

        S_FIN: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_action      <= ACT_SPEED;
            out_speed_a     <= sat16(sa_r);
            out_speed_b     <= sat16(rev_r ? -sb_r : sb_r);
            out_accel_out   <= accel_r;
            out_halted      <= 1'b0;
            out_fault       <= FLT_NONE;
            out_fault_servo <= 1'b0;
            out_position_a  <= pa_ext[31:0];
            out_position_b  <= pb_ext[31:0];
            out_last        <= 1'b1;
            state_r         <= S_IDLE;
          end
        end

        S_SIMPLE: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_action      <= act_r;
            out_speed_a     <= '0;
            out_speed_b     <= '0;
            out_accel_out   <= '0;
            out_halted      <= 1'b0;
            out_fault       <= fault_r;
            out_fault_servo <= fsv_r;
            out_position_a  <= pa_ext[31:0];
            out_position_b  <= pb_ext[31:0];
            out_last        <= 1'b1;
            state_r         <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> out_speed_a == 16'sd0 && out_speed_b == 16'sd0)
    else $error("halted result carries nonzero speed");

  a_fault_torque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault != FLT_NONE |-> out_action == ACT_TORQUE)
    else $error("fault reported without torque off");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    prev_f_r <= 17'(FACTOR_ONE))
    else $error("previous factor above one");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_speed_a) && $stable(out_speed_b) && $stable(out_last))
    else $error("stalled result beat changed");
`endif

endmodule
